// File: rtl/pl0ts_pkg.sv
package pl0ts_pkg;

    localparam int IDENT_MAX_DEF      = 11;
    localparam int NUM_DIGITS_MAX_DEF = 5;
    localparam int RUN_MAX_DEF        = 16;

    // job length field covers the largest run or word length in range
    localparam int LEN_W      = 7;
    localparam int VAL_W      = 17;
    localparam int KIND_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int JOBQ_DEPTH = 4;
    localparam int KW_N       = 15;
    localparam int KW_CHARS   = 9;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [KIND_W-1:0] K_NULL       = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT      = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER     = 6'd2;
    localparam logic [KIND_W-1:0] K_PLUS       = 6'd3;
    localparam logic [KIND_W-1:0] K_MINUS      = 6'd4;
    localparam logic [KIND_W-1:0] K_TIMES      = 6'd5;
    localparam logic [KIND_W-1:0] K_SLASH      = 6'd6;
    localparam logic [KIND_W-1:0] K_FI         = 6'd7;
    localparam logic [KIND_W-1:0] K_EQL        = 6'd8;
    localparam logic [KIND_W-1:0] K_NEQ        = 6'd9;
    localparam logic [KIND_W-1:0] K_LSS        = 6'd10;
    localparam logic [KIND_W-1:0] K_LEQ        = 6'd11;
    localparam logic [KIND_W-1:0] K_GTR        = 6'd12;
    localparam logic [KIND_W-1:0] K_GEQ        = 6'd13;
    localparam logic [KIND_W-1:0] K_LPAREN     = 6'd14;
    localparam logic [KIND_W-1:0] K_RPAREN     = 6'd15;
    localparam logic [KIND_W-1:0] K_COMMA      = 6'd16;
    localparam logic [KIND_W-1:0] K_SEMI       = 6'd17;
    localparam logic [KIND_W-1:0] K_PERIOD     = 6'd18;
    localparam logic [KIND_W-1:0] K_BECOMES    = 6'd19;
    localparam logic [KIND_W-1:0] K_BEGIN      = 6'd20;
    localparam logic [KIND_W-1:0] K_END        = 6'd21;
    localparam logic [KIND_W-1:0] K_IF         = 6'd22;
    localparam logic [KIND_W-1:0] K_THEN       = 6'd23;
    localparam logic [KIND_W-1:0] K_WHILE      = 6'd24;
    localparam logic [KIND_W-1:0] K_DO         = 6'd25;
    localparam logic [KIND_W-1:0] K_CALL       = 6'd26;
    localparam logic [KIND_W-1:0] K_CONST      = 6'd27;
    localparam logic [KIND_W-1:0] K_VAR        = 6'd28;
    localparam logic [KIND_W-1:0] K_PROCEDURE  = 6'd29;
    localparam logic [KIND_W-1:0] K_WRITE      = 6'd30;
    localparam logic [KIND_W-1:0] K_READ       = 6'd31;
    localparam logic [KIND_W-1:0] K_ELSE       = 6'd32;
    localparam logic [KIND_W-1:0] K_BAD_SYM    = 6'd33;
    localparam logic [KIND_W-1:0] K_LONG_IDENT = 6'd34;
    localparam logic [KIND_W-1:0] K_LONG_NUM   = 6'd35;

    typedef enum logic [1:0] {
        JOB_IDENT,
        JOB_NUM,
        JOB_RUN
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  value;
        logic              too_long;
        logic              last;
    } t_job;

    // keywords left aligned, zero padded
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_N] = '{
        {"null", 40'h0}, {"begin", 32'h0}, {"end", 48'h0}, {"if", 56'h0},
        {"fi", 56'h0}, {"then", 40'h0}, {"while", 32'h0}, {"do", 56'h0},
        {"call", 40'h0}, {"const", 32'h0}, {"var", 48'h0}, {"procedure"},
        {"write", 32'h0}, {"read", 40'h0}, {"else", 40'h0}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_N] = '{
        7'd4, 7'd5, 7'd3, 7'd2, 7'd2, 7'd4, 7'd5, 7'd2,
        7'd4, 7'd5, 7'd3, 7'd9, 7'd5, 7'd4, 7'd4
    };
    localparam logic [KIND_W-1:0] KW_KIND [KW_N] = '{
        K_NULL, K_BEGIN, K_END, K_IF, K_FI, K_THEN, K_WHILE, K_DO,
        K_CALL, K_CONST, K_VAR, K_PROCEDURE, K_WRITE, K_READ, K_ELSE
    };

    function automatic logic [KIND_W-1:0] single_sym(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h2b:   k = K_PLUS;
            8'h2d:   k = K_MINUS;
            8'h2a:   k = K_TIMES;
            8'h2f:   k = K_SLASH;
            8'h3d:   k = K_EQL;
            8'h3c:   k = K_LSS;
            8'h3e:   k = K_GTR;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h2c:   k = K_COMMA;
            8'h3b:   k = K_SEMI;
            8'h2e:   k = K_PERIOD;
            default: k = K_BAD_SYM;
        endcase
        return k;
    endfunction

    // miss gives the invalid symbol code
    function automatic logic [KIND_W-1:0] pair_sym(input logic [CHAR_W-1:0] a,
                                                   input logic [CHAR_W-1:0] b);
        logic [KIND_W-1:0] k;
        k = K_BAD_SYM;
        if (a == 8'h3c && b == 8'h3e) k = K_NEQ;
        if (a == 8'h3c && b == 8'h3d) k = K_LEQ;
        if (a == 8'h3e && b == 8'h3d) k = K_GEQ;
        if (a == 8'h3a && b == 8'h3d) k = K_BECOMES;
        return k;
    endfunction

    // miss gives the identifier code
    function automatic logic [KIND_W-1:0] kw_lookup(
        input logic [KW_CHARS-1:0][CHAR_W-1:0] w,
        input logic [LEN_W-1:0]                len
    );
        logic [8*KW_CHARS-1:0] p;
        logic [KIND_W-1:0]     k;
        p = '0;
        k = K_IDENT;
        for (int j = 0; j < KW_CHARS; j++) begin
            if (LEN_W'(j) < len) p[8*(KW_CHARS-1-j) +: 8] = w[j];
        end
        for (int i = 0; i < KW_N; i++) begin
            if (len == KW_LEN[i] && p == KW_TEXT[i]) k = KW_KIND[i];
        end
        return k;
    endfunction

endpackage

// File: rtl/pl0ts_front.sv
module pl0ts_front #(
    parameter int IDENT_MAX      = pl0ts_pkg::IDENT_MAX_DEF,
    parameter int NUM_DIGITS_MAX = pl0ts_pkg::NUM_DIGITS_MAX_DEF,
    parameter int RUN_MAX        = pl0ts_pkg::RUN_MAX_DEF,
    localparam int BUF_N = (IDENT_MAX > RUN_MAX) ? IDENT_MAX : RUN_MAX
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [pl0ts_pkg::CHAR_W-1:0]           i_ch,
    input  logic                                   i_eoi,
    output pl0ts_pkg::t_job                        o_job0,
    output pl0ts_pkg::t_job                        o_job1,
    output logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] o_buf0,
    output logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] o_buf1,
    output logic [1:0]                             o_wcnt
);
    import pl0ts_pkg::*;

    localparam int LMAX = ((IDENT_MAX + 1) > RUN_MAX) ? (IDENT_MAX + 1) : RUN_MAX;
    localparam int LW   = $clog2(LMAX + 1);
    localparam int IW   = $clog2(BUF_N);
    localparam int DW   = $clog2(NUM_DIGITS_MAX + 2);

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_SYMBOL,
        M_COMMENT
    } t_mode;

    t_mode                          r_mode, n_mode;
    logic [BUF_N-1:0][CHAR_W-1:0]   r_buf, n_buf;
    logic [LW-1:0]                  r_len, n_len;
    logic [VAL_W-1:0]               r_acc, n_acc;
    logic [DW-1:0]                  r_dcnt, n_dcnt;
    logic                           r_star, n_star;

    t_mode                          m;
    logic [BUF_N-1:0][CHAR_W-1:0]   mbuf, ins_buf, j1buf;
    logic [LW-1:0]                  mlen, lm1;
    logic [VAL_W-1:0]               macc, acc10;
    logic [DW-1:0]                  mdcnt;
    logic                           mstar;
    logic                           alpha, digit, blank, sym, prev_slash;
    logic [CHAR_W-1:0]              dval;
    logic                           j1v, j2v;
    t_job                           j1, j2;

    function automatic logic flush_ok(input t_mode fm, input logic [LW-1:0] len);
        return (fm == M_IDENT) || (fm == M_NUMBER) || (fm == M_SYMBOL && len != '0);
    endfunction

    function automatic t_job flush_job(input t_mode fm, input logic [LW-1:0] len,
                                       input logic [VAL_W-1:0] acc,
                                       input logic [DW-1:0] dcnt);
        t_job j;
        j.kind     = (fm == M_IDENT) ? JOB_IDENT : (fm == M_NUMBER) ? JOB_NUM : JOB_RUN;
        j.len      = LEN_W'(len);
        j.value    = acc;
        j.too_long = (fm == M_IDENT) ? (len > LW'(IDENT_MAX)) : (dcnt > DW'(NUM_DIGITS_MAX));
        j.last     = 1'b0;
        return j;
    endfunction

    always_comb begin
        alpha = (i_ch >= 8'h61 && i_ch <= 8'h7a) || (i_ch >= 8'h41 && i_ch <= 8'h5a);
        digit = (i_ch >= 8'h30 && i_ch <= 8'h39);
        blank = (i_ch == 8'h20) || (i_ch >= 8'h09 && i_ch <= 8'h0d) || (i_ch == 8'h00);
        sym   = !alpha && !digit && !blank;
        dval  = i_ch - CH_ZERO;
        acc10 = (r_acc << 3) + (r_acc << 1) + {{(VAL_W-CHAR_W){1'b0}}, dval};
        lm1   = r_len - LW'(1);
        prev_slash = (r_len != '0) && (r_buf[lm1[IW-1:0]] == CH_SLASH);
        ins_buf = r_buf;
        if (r_len < LW'(BUF_N)) ins_buf[r_len[IW-1:0]] = i_ch;

        m     = r_mode;
        mbuf  = r_buf;
        mlen  = r_len;
        macc  = r_acc;
        mdcnt = r_dcnt;
        mstar = r_star;
        j1v   = 1'b0;
        j1    = flush_job(r_mode, r_len, r_acc, r_dcnt);
        j1buf = r_buf;

        if (r_mode == M_COMMENT) begin
            if (r_star && i_ch == CH_SLASH) begin
                m     = M_IDLE;
                mstar = 1'b0;
            end else begin
                mstar = (i_ch == CH_STAR);
            end
        end else if (r_mode == M_IDENT && (alpha || digit)) begin
            if (r_len < LW'(IDENT_MAX)) mbuf = ins_buf;
            if (r_len <= LW'(IDENT_MAX)) mlen = r_len + LW'(1);
        end else if (r_mode == M_NUMBER && digit) begin
            if (r_dcnt < DW'(NUM_DIGITS_MAX)) macc = acc10;
            if (r_dcnt <= DW'(NUM_DIGITS_MAX)) mdcnt = r_dcnt + DW'(1);
        end else if (r_mode == M_SYMBOL && sym) begin
            if (i_ch == CH_STAR && prev_slash) begin
                // drop the slash, send what came before, open the comment
                j1v   = (lm1 != '0);
                j1    = flush_job(M_SYMBOL, lm1, r_acc, r_dcnt);
                m     = M_COMMENT;
                mlen  = '0;
                mstar = 1'b0;
            end else if (r_len == LW'(RUN_MAX - 1)) begin
                j1v   = 1'b1;
                j1    = flush_job(M_SYMBOL, r_len, r_acc, r_dcnt);
                j1buf = ins_buf;
                if (i_ch == CH_SLASH) begin
                    // a trailing slash may still open a comment
                    j1.len  = LEN_W'(RUN_MAX - 1);
                    mbuf[0] = CH_SLASH;
                    mlen    = LW'(1);
                end else begin
                    j1.len = LEN_W'(RUN_MAX);
                    m      = M_IDLE;
                    mlen   = '0;
                end
            end else begin
                mbuf = ins_buf;
                mlen = r_len + LW'(1);
            end
        end else begin
            j1v     = flush_ok(r_mode, r_len);
            m       = M_IDLE;
            mlen    = '0;
            macc    = '0;
            mdcnt   = '0;
            mbuf[0] = i_ch;
            if (alpha) begin
                m    = M_IDENT;
                mlen = LW'(1);
            end else if (digit) begin
                m     = M_NUMBER;
                macc  = {{(VAL_W-CHAR_W){1'b0}}, dval};
                mdcnt = DW'(1);
            end else if (sym) begin
                m    = M_SYMBOL;
                mlen = LW'(1);
            end
        end

        j2v = i_eoi && flush_ok(m, mlen);
        j2  = flush_job(m, mlen, macc, mdcnt);

        n_mode = m;
        n_buf  = mbuf;
        n_len  = mlen;
        n_acc  = macc;
        n_dcnt = mdcnt;
        n_star = mstar;
        if (i_eoi) begin
            n_mode = (m == M_COMMENT) ? M_COMMENT : M_IDLE;
            n_len  = '0;
            n_acc  = '0;
            n_dcnt = '0;
        end

        // pack the jobs of this beat, last one carries the last mark
        o_job0      = j1v ? j1 : j2;
        o_buf0      = j1v ? j1buf : mbuf;
        o_job0.last = j1v ? !j2v : 1'b1;
        o_job1      = j2;
        o_job1.last = 1'b1;
        o_buf1      = mbuf;
        o_wcnt      = i_valid ? (2'(j1v) + 2'(j2v)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len  <= '0;
            r_acc  <= '0;
            r_dcnt <= '0;
            r_star <= 1'b0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
            r_star <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) r_buf <= n_buf;
    end

endmodule

// File: rtl/pl0ts_jobq.sv
module pl0ts_jobq #(
    parameter int BUF_N = pl0ts_pkg::RUN_MAX_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [1:0]                              i_wcnt,
    input  pl0ts_pkg::t_job                         i_job0,
    input  pl0ts_pkg::t_job                         i_job1,
    input  logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] i_buf0,
    input  logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] i_buf1,
    output logic                                    o_full,
    output logic                                    o_valid,
    output pl0ts_pkg::t_job                         o_job,
    output logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] o_buf,
    input  logic                                    i_pop
);
    import pl0ts_pkg::*;

    localparam int PW = $clog2(JOBQ_DEPTH);
    localparam int CW = $clog2(JOBQ_DEPTH + 1);

    t_job                         r_job [JOBQ_DEPTH];
    logic [BUF_N-1:0][CHAR_W-1:0] r_buf [JOBQ_DEPTH];
    logic [PW-1:0]                r_wp, r_rp, wp1;
    logic [CW-1:0]                r_cnt;

    assign wp1     = r_wp + PW'(1);
    // a beat may bring two jobs, so keep two slots free
    assign o_full  = r_cnt > CW'(JOBQ_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_job[r_rp];
    assign o_buf   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wcnt != 2'd0) begin
            r_job[r_wp] <= i_job0;
            r_buf[r_wp] <= i_buf0;
        end
        if (i_wcnt == 2'd2) begin
            r_job[wp1] <= i_job1;
            r_buf[wp1] <= i_buf1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_wcnt);
            if (i_pop) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + CW'(i_wcnt) - CW'(i_pop);
        end
    end

endmodule

// File: rtl/pl0ts_back.sv
module pl0ts_back #(
    parameter int BUF_N = pl0ts_pkg::RUN_MAX_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  pl0ts_pkg::t_job                         i_job,
    input  logic [BUF_N-1:0][pl0ts_pkg::CHAR_W-1:0] i_buf,
    output logic                                    o_pop,
    input  logic                                    i_out_pop,
    output logic                                    o_empty,
    output logic [pl0ts_pkg::KIND_W-1:0]            o_token_kind,
    output logic [pl0ts_pkg::CHAR_W-1:0]            o_lexeme_char,
    output logic [pl0ts_pkg::VAL_W-1:0]             o_number_value,
    output logic                                    o_last
);
    import pl0ts_pkg::*;

    localparam int IW = $clog2(BUF_N);

    logic [LEN_W-1:0]                r_idx;
    logic                            r_ovalid;
    logic [KIND_W-1:0]               r_kind, kind, kw_kind, pair_kind;
    logic [CHAR_W-1:0]               r_char, lex, cur;
    logic [VAL_W-1:0]                r_val, val;
    logic                            r_last;
    logic                            single, final_beat, adv;
    logic [KW_CHARS-1:0][CHAR_W-1:0] w;

    always_comb begin
        w = '0;
        for (int j = 0; j < KW_CHARS; j++) begin
            if (j < BUF_N) w[j] = i_buf[j];
        end
        kw_kind   = kw_lookup(w, i_job.len);
        pair_kind = pair_sym(i_buf[0], i_buf[1]);
        cur       = i_buf[r_idx[IW-1:0]];

        single = 1'b0;
        kind   = single_sym(cur);
        lex    = '0;
        val    = '0;
        case (i_job.kind)
            JOB_IDENT: begin
                if (i_job.too_long) begin
                    single = 1'b1;
                    kind   = K_LONG_IDENT;
                end else if (kw_kind != K_IDENT) begin
                    single = 1'b1;
                    kind   = kw_kind;
                end else begin
                    kind = K_IDENT;
                    lex  = cur;
                end
            end
            JOB_NUM: begin
                single = 1'b1;
                kind   = i_job.too_long ? K_LONG_NUM : K_NUMBER;
                val    = i_job.too_long ? '0 : i_job.value;
            end
            JOB_RUN: begin
                // a valid pair is one token, anything else splits per char
                if (i_job.len == LEN_W'(2) && pair_kind != K_BAD_SYM) begin
                    single = 1'b1;
                    kind   = pair_kind;
                end
            end
            default: begin
                single = 1'b1;
                kind   = K_BAD_SYM;
            end
        endcase

        final_beat = single || (r_idx == i_job.len - LEN_W'(1));
        adv        = i_valid && (!r_ovalid || i_out_pop);
        o_pop      = adv && final_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
                r_idx    <= final_beat ? '0 : r_idx + LEN_W'(1);
            end else if (i_out_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind <= kind;
            r_char <= lex;
            r_val  <= val;
            r_last <= i_job.last && final_beat;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_token_kind   = r_kind;
    assign o_lexeme_char  = r_char;
    assign o_number_value = r_val;
    assign o_last         = r_last;

endmodule

// File: rtl/pl0_token_scanner.sv
// pl0 token scanner
// source characters go in through a queue style port: push with full, one
// character a beat, end_of_input flushes whatever token is pending after it.
// tokens come out through a queue style port: empty with pop, one result a
// beat; identifiers that are not keywords come out one character a beat, and
// symbol runs that are not a valid symbol come out one token per character.
// last marks the final result caused by one input character.
// the front takes one character per cycle and never waits on the output as
// long as the job queue (four entries) has two free slots; each character
// yields at most two jobs. the back turns each job into its results, one
// result per cycle while pop keeps the output register free.
// the first result of a character passes through the job queue and the
// back's output register before it reaches the port.
// when pop stays low the output register holds, the back stalls, the queue
// fills and full rises; no result is dropped.
// reset clears the scan state, the queue and the output register: empty is
// high and full is low in the cycle after reset.
module pl0_token_scanner #(
    parameter int IDENT_MAX      = pl0ts_pkg::IDENT_MAX_DEF,
    parameter int NUM_DIGITS_MAX = pl0ts_pkg::NUM_DIGITS_MAX_DEF,
    parameter int RUN_MAX        = pl0ts_pkg::RUN_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [pl0ts_pkg::CHAR_W-1:0]  i_ch,
    input  logic                          i_end_of_input,
    output logic                          empty,
    input  logic                          pop,
    output logic [pl0ts_pkg::KIND_W-1:0]  o_token_kind,
    output logic [pl0ts_pkg::CHAR_W-1:0]  o_lexeme_char,
    output logic [pl0ts_pkg::VAL_W-1:0]   o_number_value,
    output logic                          o_last
);
    import pl0ts_pkg::*;

    localparam int BUF_N = (IDENT_MAX > RUN_MAX) ? IDENT_MAX : RUN_MAX;

    logic                         accept, q_valid, q_pop;
    logic [1:0]                   wcnt;
    t_job                         job0, job1, q_job;
    logic [BUF_N-1:0][CHAR_W-1:0] buf0, buf1, q_buf;

    assign accept = push && !full;

    pl0ts_front #(
        .IDENT_MAX      (IDENT_MAX),
        .NUM_DIGITS_MAX (NUM_DIGITS_MAX),
        .RUN_MAX        (RUN_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ch    (i_ch),
        .i_eoi   (i_end_of_input),
        .o_job0  (job0),
        .o_job1  (job1),
        .o_buf0  (buf0),
        .o_buf1  (buf1),
        .o_wcnt  (wcnt)
    );

    pl0ts_jobq #(
        .BUF_N (BUF_N)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wcnt  (wcnt),
        .i_job0  (job0),
        .i_job1  (job1),
        .i_buf0  (buf0),
        .i_buf1  (buf1),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_buf   (q_buf),
        .i_pop   (q_pop)
    );

    pl0ts_back #(
        .BUF_N (BUF_N)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_job          (q_job),
        .i_buf          (q_buf),
        .o_pop          (q_pop),
        .i_out_pop      (pop),
        .o_empty        (empty),
        .o_token_kind   (o_token_kind),
        .o_lexeme_char  (o_lexeme_char),
        .o_number_value (o_number_value),
        .o_last         (o_last)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_lexeme_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != K_IDENT) |-> (o_lexeme_char == '0))
        else $error("lexeme char on a non identifier token");

    a_value_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != K_NUMBER) |-> (o_number_value == '0))
        else $error("number value on a non number token");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_token_kind <= K_LONG_NUM))
        else $error("token kind out of range");

endmodule

// File: tb/sv/pl0_token_scanner_checker.sv
module pl0_token_scanner_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic [pl0ts_pkg::CHAR_W-1:0] i_ch,
    input  logic                         i_end_of_input,
    input  logic                         i_empty,
    input  logic                         i_pop,
    input  logic [pl0ts_pkg::KIND_W-1:0] i_token_kind,
    input  logic [pl0ts_pkg::CHAR_W-1:0] i_lexeme_char,
    input  logic [pl0ts_pkg::VAL_W-1:0]  i_number_value,
    input  logic                         i_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pl0ts_pkg::*;

    localparam int WORD_MAX  = IDENT_MAX_DEF;
    localparam int DIGIT_MAX = NUM_DIGITS_MAX_DEF;
    localparam int RUN_LIMIT = RUN_MAX_DEF;

    typedef enum int {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_SYMBOL, SCAN_COMMENT} t_scan;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] lch;
        logic [VAL_W-1:0]  val;
        logic              last;
    } t_token;

    string             kw_text [KW_N] = '{"null", "begin", "end", "if", "fi", "then", "while",
                                          "do", "call", "const", "var", "procedure", "write",
                                          "read", "else"};
    logic [KIND_W-1:0] kw_code [KW_N] = '{K_NULL, K_BEGIN, K_END, K_IF, K_FI, K_THEN,
                                          K_WHILE, K_DO, K_CALL, K_CONST, K_VAR,
                                          K_PROCEDURE, K_WRITE, K_READ, K_ELSE};

    t_scan       mode;
    logic [7:0]  word_buf [WORD_MAX];
    int          word_len;
    int          num_acc;
    int          num_digits;
    logic [7:0]  run_buf [RUN_LIMIT];
    int          run_len;
    bit          star_pending;
    t_token      step_tokens [$];
    t_token      expected_tokens [$];
    int          fails;

    function automatic void put_token(logic [KIND_W-1:0] kind, logic [7:0] c, int val);
        t_token t;
        t.kind = kind;
        t.lch  = c;
        t.val  = VAL_W'(val);
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic int single_code(logic [7:0] c);
        case (c)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_TIMES;
            "/":     return K_SLASH;
            "=":     return K_EQL;
            "<":     return K_LSS;
            ">":     return K_GTR;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            ",":     return K_COMMA;
            ";":     return K_SEMI;
            ".":     return K_PERIOD;
            default: return -1;
        endcase
    endfunction

    function automatic int pair_code(logic [7:0] a, logic [7:0] b);
        if (a == "<" && b == ">") return K_NEQ;
        if (a == "<" && b == "=") return K_LEQ;
        if (a == ">" && b == "=") return K_GEQ;
        if (a == ":" && b == "=") return K_BECOMES;
        return -1;
    endfunction

    function automatic void emit_symbols(int count);
        int k;
        k = -1;
        if (count == 0) return;
        if (count == 1) k = single_code(run_buf[0]);
        else if (count == 2) k = pair_code(run_buf[0], run_buf[1]);
        if (k >= 0) begin
            put_token(KIND_W'(k), 8'd0, 0);
            return;
        end
        for (int i = 0; i < count; i++) begin
            k = single_code(run_buf[i]);
            put_token(k >= 0 ? KIND_W'(k) : K_BAD_SYM, 8'd0, 0);
        end
    endfunction

    function automatic void emit_word();
        bit same;
        if (word_len > WORD_MAX) begin
            put_token(K_LONG_IDENT, 8'd0, 0);
            return;
        end
        for (int i = 0; i < KW_N; i++) begin
            same = (kw_text[i].len() == word_len);
            for (int j = 0; same && j < word_len; j++)
                if (kw_text[i][j] != word_buf[j]) same = 0;
            if (same) begin
                put_token(kw_code[i], 8'd0, 0);
                return;
            end
        end
        for (int i = 0; i < word_len; i++) put_token(K_IDENT, word_buf[i], 0);
    endfunction

    function automatic void flush_token();
        if (mode == SCAN_WORD) emit_word();
        else if (mode == SCAN_NUMBER) begin
            if (num_digits > DIGIT_MAX) put_token(K_LONG_NUM, 8'd0, 0);
            else put_token(K_NUMBER, 8'd0, num_acc);
        end else if (mode == SCAN_SYMBOL) emit_symbols(run_len);
        if (mode != SCAN_COMMENT) mode = SCAN_IDLE;
        word_len   = 0;
        num_acc    = 0;
        num_digits = 0;
        run_len    = 0;
    endfunction

    function automatic void add_letter(logic [7:0] c);
        if (word_len < WORD_MAX) word_buf[word_len] = c;
        if (word_len <= WORD_MAX) word_len++;
    endfunction

    function automatic void add_digit(logic [7:0] c);
        if (num_digits < DIGIT_MAX) num_acc = num_acc * 10 + int'(c - "0");
        if (num_digits <= DIGIT_MAX) num_digits++;
    endfunction

    function automatic void add_symbol(logic [7:0] c);
        // slash then star opens a comment, the slash is dropped
        if (c == "*" && run_len > 0 && run_buf[run_len-1] == "/") begin
            run_len--;
            emit_symbols(run_len);
            run_len      = 0;
            mode         = SCAN_COMMENT;
            star_pending = 0;
            return;
        end
        if (run_len >= RUN_LIMIT) run_len = 0;
        run_buf[run_len] = c;
        run_len++;
        mode = SCAN_SYMBOL;
        if (run_len == RUN_LIMIT) begin
            if (c == "/") begin
                // trailing slash may still open a comment
                emit_symbols(RUN_LIMIT - 1);
                run_buf[0] = "/";
                run_len    = 1;
            end else begin
                emit_symbols(RUN_LIMIT);
                run_len = 0;
                mode    = SCAN_IDLE;
            end
        end
    endfunction

    function automatic void scan_char(logic [7:0] c, logic eoi);
        bit alpha, digit, blank;
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit = (c >= "0" && c <= "9");
        blank = c == " " || (c >= 8'd9 && c <= 8'd13) || c == 8'd0;
        step_tokens.delete();
        if (mode == SCAN_COMMENT) begin
            if (star_pending && c == "/") begin
                mode         = SCAN_IDLE;
                star_pending = 0;
            end else star_pending = (c == "*");
        end else if (mode == SCAN_WORD && (alpha || digit)) add_letter(c);
        else if (mode == SCAN_NUMBER && digit) add_digit(c);
        else if (mode == SCAN_SYMBOL && !alpha && !digit && !blank) add_symbol(c);
        else begin
            flush_token();
            if (alpha) begin
                mode = SCAN_WORD;
                add_letter(c);
            end else if (digit) begin
                mode = SCAN_NUMBER;
                add_digit(c);
            end else if (!blank) add_symbol(c);
        end
        if (eoi) flush_token();
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            mode         <= SCAN_IDLE;
            word_len     <= 0;
            num_acc      <= 0;
            num_digits   <= 0;
            run_len      <= 0;
            star_pending <= 0;
            fails        <= 0;
            expected_tokens.delete();
        end else begin
            if (i_push && !i_full) scan_char(i_ch, i_end_of_input);
            if (i_pop && !i_empty) begin
                if (expected_tokens.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected token kind=%0d char=%0d val=%0d last=%0b",
                                 i_token_kind, i_lexeme_char, i_number_value, i_last);
                    fails <= fails + 1;
                end else begin
                    want = expected_tokens.pop_front();
                    if (want.kind !== i_token_kind || want.lch !== i_lexeme_char ||
                        want.val !== i_number_value || want.last !== i_last) begin
                        if (fails < 10)
                            $display({"token mismatch: exp kind=%0d char=%0d val=%0d ",
                                      "last=%0b, got kind=%0d char=%0d val=%0d last=%0b"},
                                     want.kind, want.lch, want.val, want.last,
                                     i_token_kind, i_lexeme_char, i_number_value, i_last);
                        fails <= fails + 1;
                    end
                end
            end
        end
        o_pending = expected_tokens.size();
    end

    assign o_fail_count = fails;

endmodule

// File: tb/sv/pl0_token_scanner_tb.sv
module pl0_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pl0ts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [CHAR_W-1:0] i_ch;
    logic              i_end_of_input;
    logic              empty;
    logic              pop;
    logic [KIND_W-1:0] o_token_kind;
    logic [CHAR_W-1:0] o_lexeme_char;
    logic [VAL_W-1:0]  o_number_value;
    logic              o_last;
    int                fail_count;
    int                pending;
    int                send_idle_pct;
    int                take_idle_pct;
    int                hold_request;
    int                chars_sent;
    int                cycles;

    string keywords [15] = '{"null", "begin", "end", "if", "fi", "then", "while", "do",
                             "call", "const", "var", "procedure", "write", "read", "else"};
    string symbols  [10] = '{":=", "<>", "<=", ">=", "+", ";", "(", ")", ",", "."};

    pl0_token_scanner DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (o_token_kind),
        .o_lexeme_char  (o_lexeme_char),
        .o_number_value (o_number_value),
        .o_last         (o_last)
    );

    pl0_token_scanner_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_ch           (i_ch),
        .i_end_of_input (i_end_of_input),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_token_kind   (o_token_kind),
        .i_lexeme_char  (o_lexeme_char),
        .i_number_value (o_number_value),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver, with a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else pop <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_ch           <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (full);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic eoi_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eoi_at_end && i == s.len() - 1);
    endtask

    function automatic string random_lexeme();
        string s;
        int    n;
        s = "";
        case ($urandom_range(9))
            0, 1: begin
                s = keywords[$urandom_range(14)];
                if ($urandom_range(7) == 0) s[0] = s[0] - 8'd32;
            end
            2, 3: begin
                n = ($urandom_range(5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
                s = {s, string'(8'($urandom_range(1) ? $urandom_range("a", "z")
                                                     : $urandom_range("A", "Z")))};
                for (int i = 1; i < n; i++)
                    s = {s, string'(8'($urandom_range(2) ? $urandom_range("a", "z")
                                                         : $urandom_range("0", "9")))};
            end
            4, 5: begin
                n = ($urandom_range(4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
            end
            6: s = symbols[$urandom_range(9)];
            7: begin
                n = ($urandom_range(5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(3) == 0 ? "/" : $urandom_range(33, 47)))};
            end
            8: s = "/* a*b */";
            default: s = {s, string'(8'($urandom_range(255)))};
        endcase
        return s;
    endfunction

    task automatic random_phase(input int count);
        string s;
        int    start;
        start = chars_sent;
        while (chars_sent - start < count) begin
            s = random_lexeme();
            if (s.len() == 0) continue;
            send_text(s, 1'b0);
            case ($urandom_range(9))
                0:       send_char("\n", 1'b0);
                1:       send_char("\t", 1'b0);
                2:       ;
                3:       send_char(" ", 1'b1);
                default: send_char(" ", 1'b0);
            endcase
        end
    endtask

    initial begin
        hold_request   = 0;
        chars_sent     = 0;
        send_idle_pct  = 31;
        take_idle_pct  = 59;
        push           = 1'b0;
        i_ch           = '0;
        i_end_of_input = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes: long word, long number, max value, broken run, comments, odd bytes
        send_text("abcdefghijkl 99999 123456 fi", 1'b0);
        send_text("<>?/*x/*/", 1'b1);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        random_phase(60);

        // stall the output long enough for the input to back up
        hold_request = 400;
        send_text("++++++++++++++++ +++++++++++++++/* */ a1b2c3d4e5f ", 1'b0);
        random_phase(40);

        send_idle_pct = 59;
        take_idle_pct = 31;
        random_phase(70);
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(45);
        send_char(" ", 1'b1);
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// File: pl0_token_scanner.f
rtl/pl0ts_pkg.sv
rtl/pl0ts_front.sv
rtl/pl0ts_jobq.sv
rtl/pl0ts_back.sv
rtl/pl0_token_scanner.sv
tb/sv/pl0_token_scanner_checker.sv
tb/sv/pl0_token_scanner_tb.sv
